// File: hdl/gpio_pkg.sv
// GPIO port package: pin count, register and opcode codes, word types.
// No dependencies; used by every module in hdl/.
package gpio_pkg;

	localparam int PIN_COUNT = 32;

	localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

	// Two-bit mode fields that exist for real pins, per ICR word
	function automatic logic [31:0] icr_mask_f(input int upper);
		logic [31:0] m;
		m = '0;
		for (int p = 0; p < 16; p++) begin
			if (p + 16 * upper < PIN_COUNT) begin
				m[2*p +: 2] = 2'b11;
			end
		end
		return m;
	endfunction

	localparam logic [31:0] ICR_LO_MASK = icr_mask_f(0);
	localparam logic [31:0] ICR_HI_MASK = icr_mask_f(1);

	localparam logic [31:0] IRQ_LO_PINS = 32'h0000_ffff;
	localparam logic [31:0] IRQ_HI_PINS = 32'hffff_0000;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_DATA    = 3'd0,
		REG_DIR     = 3'd1,
		REG_PSR     = 3'd2,
		REG_ICR1    = 3'd3,
		REG_ICR2    = 3'd4,
		REG_MASK    = 3'd5,
		REG_STATUS  = 3'd6,
		REG_EDGESEL = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_LOW  = 2'd0,
		MODE_HIGH = 2'd1,
		MODE_RISE = 2'd2,
		MODE_FALL = 2'd3
	} icr_mode_t;

	typedef struct packed {
		op_t         op;
		reg_idx_t    idx;
		logic [31:0] write_data;
		logic [31:0] pad_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] pad_out;
		logic [31:0] pad_dir;
		logic        irq_low;
		logic        irq_upper;
	} res_t;

endpackage

// File: hdl/gpio_if.sv
// Valid/ready channel interfaces for the GPIO port: access words in, result words out.
// Depends on nothing but the wires they carry.
interface gpio_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [2:0]  reg_index;
	logic [31:0] write_data;
	logic [31:0] pad_in;

	modport source (output valid, opcode, reg_index, write_data, pad_in, input ready);
	modport sink (input valid, opcode, reg_index, write_data, pad_in, output ready);
endinterface

interface gpio_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [31:0] pad_out;
	logic [31:0] pad_dir;
	logic        irq_low;
	logic        irq_upper;

	modport source (output valid, read_data, pad_out, pad_dir, irq_low, irq_upper, input ready);
	modport sink (input valid, read_data, pad_out, pad_dir, irq_low, irq_upper, output ready);
endinterface

// File: hdl/gpio_detect.sv
// Per-pin interrupt condition detector: level, edge and any-edge.
// Depends on gpio_pkg.
module gpio_detect
	import gpio_pkg::*;
(
	input  logic [31:0] pads,
	input  logic [31:0] last_pads,
	input  logic [31:0] icr_lo,
	input  logic [31:0] icr_hi,
	input  logic [31:0] edge_any,
	output logic [31:0] hit
);

	for (genvar p = 0; p < 32; p++) begin : g_pin
		if (p < PIN_COUNT) begin : g_real
			icr_mode_t mode;
			logic      now_b;
			logic      prev_b;
			logic      hit_b;

			assign now_b  = pads[p];
			assign prev_b = last_pads[p];

			if (p < 16) begin : g_lo
				assign mode = icr_mode_t'(icr_lo[2*p +: 2]);
			end else begin : g_hi
				assign mode = icr_mode_t'(icr_hi[2*(p-16) +: 2]);
			end

			always_comb begin
				if (edge_any[p]) begin
					hit_b = now_b ^ prev_b;
				end else begin
					case (mode)
						MODE_LOW:  hit_b = ~now_b;
						MODE_HIGH: hit_b = now_b;
						MODE_RISE: hit_b = ~prev_b & now_b;
						MODE_FALL: hit_b = prev_b & ~now_b;
						default:   hit_b = 1'b0;
					endcase
				end
			end

			assign hit[p] = hit_b;
		end else begin : g_absent
			assign hit[p] = 1'b0;
		end
	end

endmodule

// File: hdl/gpio_regs.sv
// GPIO register file: eight words, sticky status and pad history.
// Depends on gpio_pkg and gpio_detect.
module gpio_regs
	import gpio_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cmd_t cmd,
	output res_t res
);

	logic [31:0] data_q, dir_q, icr_lo_q, icr_hi_q, mask_q, status_q, edge_any_q, last_pads_q;
	logic [31:0] data_d, dir_d, icr_lo_d, icr_hi_d, mask_d, status_d, edge_any_d, last_pads_d;
	logic [31:0] hit;
	logic [31:0] rd;
	logic [31:0] act;

	gpio_detect u_detect (
		.pads      (cmd.pad_in),
		.last_pads (last_pads_q),
		.icr_lo    (icr_lo_q),
		.icr_hi    (icr_hi_q),
		.edge_any  (edge_any_q),
		.hit       (hit)
	);

	always_comb begin
		data_d      = data_q;
		dir_d       = dir_q;
		icr_lo_d    = icr_lo_q;
		icr_hi_d    = icr_hi_q;
		mask_d      = mask_q;
		status_d    = status_q;
		edge_any_d  = edge_any_q;
		last_pads_d = last_pads_q;
		rd          = '0;
		case (cmd.op)
			OP_READ: begin
				case (cmd.idx)
					REG_DATA:    rd = data_q;
					REG_DIR:     rd = dir_q;
					REG_PSR:     rd = last_pads_q;
					REG_ICR1:    rd = icr_lo_q;
					REG_ICR2:    rd = icr_hi_q;
					REG_MASK:    rd = mask_q;
					REG_STATUS:  rd = status_q;
					REG_EDGESEL: rd = edge_any_q;
					default:     rd = '0;
				endcase
			end
			OP_WRITE: begin
				case (cmd.idx)
					REG_DATA:    data_d     = cmd.write_data & PIN_MASK;
					REG_DIR:     dir_d      = cmd.write_data & PIN_MASK;
					REG_ICR1:    icr_lo_d   = cmd.write_data & ICR_LO_MASK;
					REG_ICR2:    icr_hi_d   = cmd.write_data & ICR_HI_MASK;
					REG_MASK:    mask_d     = cmd.write_data & PIN_MASK;
					REG_STATUS:  status_d   = status_q & ~cmd.write_data;
					REG_EDGESEL: edge_any_d = cmd.write_data & PIN_MASK;
					default:     ;  // pad status is read only
				endcase
			end
			OP_TICK: begin
				status_d    = status_q | hit;
				last_pads_d = cmd.pad_in & PIN_MASK;
			end
			default: ;
		endcase
	end

	assign act          = status_d & mask_d;
	assign res.read_data = rd;
	assign res.pad_out   = data_d;
	assign res.pad_dir   = dir_d;
	assign res.irq_low   = |(act & IRQ_LO_PINS);
	assign res.irq_upper = |(act & IRQ_HI_PINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q      <= '0;
			dir_q       <= '0;
			icr_lo_q    <= '0;
			icr_hi_q    <= '0;
			mask_q      <= '0;
			status_q    <= '0;
			edge_any_q  <= '0;
			last_pads_q <= '0;
		end else if (step) begin
			data_q      <= data_d;
			dir_q       <= dir_d;
			icr_lo_q    <= icr_lo_d;
			icr_hi_q    <= icr_hi_d;
			mask_q      <= mask_d;
			status_q    <= status_d;
			edge_any_q  <= edge_any_d;
			last_pads_q <= last_pads_d;
		end
	end

	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd.op == OP_WRITE && cmd.idx == REG_STATUS
		|=> (status_q & $past(cmd.write_data)) == '0)
		else $error("status bits written with one were not cleared");

	a_tick_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd.op == OP_TICK
		|=> (status_q & $past(status_q)) == $past(status_q))
		else $error("tick lost a sticky status bit");

	a_tick_history: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd.op == OP_TICK |=> last_pads_q == ($past(cmd.pad_in) & PIN_MASK))
		else $error("pad history not taken on tick");

endmodule

// File: hdl/gpio_port_with_interrupts.sv
// GPIO port with interrupts, top level: input register, register file, result register.
// Depends on gpio_pkg, gpio_if (gpio_in_if, gpio_out_if) and gpio_regs.
// A word accepted into the input register passes through the register file into the result register.
// Throughput: one word per cycle while the result register drains; the register file updates on
// the edge that moves a word from the input register to the result register, so words follow back to back.
// Reset: arst_n clears all eight registers, the pad history and both valid flags.
module gpio_port_with_interrupts
	import gpio_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	gpio_in_if.sink    in_ch,
	gpio_out_if.source out_ch
);

	// Stage 1: captured access word
	logic valid_s1;
	cmd_t cmd_s1;

	// Result register
	logic out_valid_q;
	res_t res_q;

	res_t res_next;
	logic advance;

	// Stage 1 moves on whenever the result register is empty or being drained.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cmd_s1.op         <= op_t'(in_ch.opcode);
			cmd_s1.idx        <= reg_idx_t'(in_ch.reg_index);
			cmd_s1.write_data <= in_ch.write_data;
			cmd_s1.pad_in     <= in_ch.pad_in;
		end
	end

	// Register file: state commits on the same edge that loads the result.
	gpio_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.read_data = res_q.read_data;
	assign out_ch.pad_out   = res_q.pad_out;
	assign out_ch.pad_dir   = res_q.pad_dir;
	assign out_ch.irq_low   = res_q.irq_low;
	assign out_ch.irq_upper = res_q.irq_upper;

	// An empty result register never blocks the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty result register");

	// A stalled result with a waiting stage 1 must hold the input.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready && valid_s1 |-> !in_ch.ready)
		else $error("input accepted while pipeline is full");

	// Pins above the pin count never drive.
	a_absent_pins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.pad_out | res_q.pad_dir) & ~PIN_MASK) == '0)
		else $error("absent pin bit set in result");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the 32-pin GPIO port with interrupts: register access, pad ticks, IRQs.
// Depends on gpio_pkg and the gpio_in_if / gpio_out_if channels; drives the port and scores
// every result word against a cycle-free model of the eight registers and the pad history.
module tb_top;
	import gpio_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	gpio_in_if  in_ch ();
	gpio_out_if out_ch ();

	gpio_port_with_interrupts uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Pending access words, and the result words they are expected to produce
	cmd_t pending_words[$];
	res_t expected_results[$];

	// Handshake bookkeeping: a word is on the bus while issued != accepted
	int unsigned words_issued;
	int unsigned words_accepted;

	// Percent of cycles each side idles in the current phase
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	int unsigned failure_count;

	// Last pad pattern handed out, so random ticks can flip a few pins at a time
	logic [31:0] pad_trail;

	// Model of the port's state
	logic [31:0] gpio_data;
	logic [31:0] gpio_dir;
	logic [31:0] gpio_icr_lo;
	logic [31:0] gpio_icr_hi;
	logic [31:0] gpio_mask;
	logic [31:0] gpio_status;
	logic [31:0] gpio_edgesel;
	logic [31:0] gpio_pads;

	always #10 clk = ~clk;

	// Applies one accepted word to the model and returns the result word it should cause.
	function automatic res_t apply_gpio_word(cmd_t w);
		res_t r;
		logic [31:0] act;
		logic [1:0] mode;
		logic now_lvl;
		logic prev_lvl;
		logic hit;
		r.read_data = '0;
		case (w.op)
			OP_READ: begin
				case (w.idx)
					REG_DATA:    r.read_data = gpio_data;
					REG_DIR:     r.read_data = gpio_dir;
					REG_PSR:     r.read_data = gpio_pads;
					REG_ICR1:    r.read_data = gpio_icr_lo;
					REG_ICR2:    r.read_data = gpio_icr_hi;
					REG_MASK:    r.read_data = gpio_mask;
					REG_STATUS:  r.read_data = gpio_status;
					default:     r.read_data = gpio_edgesel;
				endcase
			end
			OP_WRITE: begin
				case (w.idx)
					REG_DATA:    gpio_data = w.write_data & PIN_MASK;
					REG_DIR:     gpio_dir = w.write_data & PIN_MASK;
					REG_PSR:     ; // pad status is read only
					REG_ICR1:    gpio_icr_lo = w.write_data & ICR_LO_MASK;
					REG_ICR2:    gpio_icr_hi = w.write_data & ICR_HI_MASK;
					REG_MASK:    gpio_mask = w.write_data & PIN_MASK;
					REG_STATUS:  gpio_status = gpio_status & ~w.write_data; // write-1-to-clear
					default:     gpio_edgesel = w.write_data & PIN_MASK;
				endcase
			end
			OP_TICK: begin
				for (int p = 0; p < 32; p++) begin
					if (PIN_MASK[p]) begin
						now_lvl = w.pad_in[p];
						prev_lvl = gpio_pads[p];
						if (gpio_edgesel[p]) begin
							// edge select wins over the ICR mode: any change
							hit = now_lvl ^ prev_lvl;
						end else begin
							mode = (p < 16) ? gpio_icr_lo[2*p +: 2] : gpio_icr_hi[2*(p-16) +: 2];
							case (icr_mode_t'(mode))
								MODE_LOW:  hit = ~now_lvl;
								MODE_HIGH: hit = now_lvl;
								MODE_RISE: hit = ~prev_lvl & now_lvl;
								default:   hit = prev_lvl & ~now_lvl;
							endcase
						end
						// sticky, regardless of mask and direction
						gpio_status[p] = gpio_status[p] | hit;
					end
				end
				gpio_pads = w.pad_in & PIN_MASK;
			end
			default: ; // opcode three does nothing
		endcase
		act = gpio_status & gpio_mask;
		r.pad_out = gpio_data;
		r.pad_dir = gpio_dir;
		r.irq_low = |(act & IRQ_LO_PINS);
		r.irq_upper = |(act & IRQ_HI_PINS);
		return r;
	endfunction

	task automatic log_failure(input string what, input res_t want, input res_t got);
		failure_count++;
		if (failure_count <= 10) begin
			$display("%0t: %s: want rd=%h out=%h dir=%h irq=%b%b, got rd=%h out=%h dir=%h irq=%b%b",
				$realtime, what, want.read_data, want.pad_out, want.pad_dir, want.irq_upper,
				want.irq_low, got.read_data, got.pad_out, got.pad_dir, got.irq_upper, got.irq_low);
		end
	endtask

	task automatic push_word(input op_t op, input reg_idx_t idx, input logic [31:0] wd,
		input logic [31:0] pads);
		cmd_t w;
		w.op = op;
		w.idx = idx;
		w.write_data = wd;
		w.pad_in = pads;
		pending_words.push_back(w);
	endtask

	// Random words: mostly reads, writes and ticks; ticks often flip only a few pins so that
	// edge modes see clean single transitions, the rest are fully random pad patterns.
	task automatic push_random(input int count);
		int unsigned sel;
		int unsigned flavor;
		logic [31:0] wd;
		logic [31:0] pads;
		reg_idx_t idx;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			idx = reg_idx_t'($urandom_range(0, 7));
			flavor = $urandom_range(0, 9);
			wd = (flavor == 0) ? 32'h0 : (flavor == 1) ? 32'hffff_ffff : $urandom;
			if ($urandom_range(0, 1) == 1) begin
				pads = pad_trail ^ ($urandom & $urandom & $urandom);
			end else begin
				pads = $urandom;
			end
			if (sel < 30) begin
				pad_trail = pads;
				push_word(OP_TICK, idx, wd, pads);
			end else if (sel < 62) begin
				push_word(OP_WRITE, idx, wd, pads);
			end else if (sel < 95) begin
				push_word(OP_READ, idx, wd, pads);
			end else begin
				push_word(OP_NONE, idx, wd, pads);
			end
		end
	endtask

	// Sender holds off until every queued word is taken and every result has come back
	task automatic wait_drained();
		while (pending_words.size() != 0 || words_issued != words_accepted ||
			expected_results.size() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Driver: presents the next pending word on a falling edge once the previous one is taken
	always @(negedge clk) begin
		cmd_t w;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (words_issued == words_accepted) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.opcode <= w.op;
				in_ch.reg_index <= w.idx;
				in_ch.write_data <= w.write_data;
				in_ch.pad_in <= w.pad_in;
				words_issued++;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: scores result words and feeds accepted access words to the model
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		cmd_t w;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.read_data = out_ch.read_data;
				got.pad_out = out_ch.pad_out;
				got.pad_dir = out_ch.pad_dir;
				got.irq_low = out_ch.irq_low;
				got.irq_upper = out_ch.irq_upper;
				if (expected_results.size() == 0) begin
					log_failure("unexpected result word", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						log_failure("result mismatch", want, got);
					end
				end
			end
			// result of this word cannot show at the same edge, so order here is free
			if (in_ch.valid && in_ch.ready) begin
				w.op = op_t'(in_ch.opcode);
				w.idx = reg_idx_t'(in_ch.reg_index);
				w.write_data = in_ch.write_data;
				w.pad_in = in_ch.pad_in;
				expected_results.push_back(apply_gpio_word(w));
				words_accepted++;
			end
		end
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("gpio_port_with_interrupts verification failed");
		$finish;
	end

	initial begin
		res_t none;
		none = '0;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.reg_index = '0;
		in_ch.write_data = '0;
		in_ch.pad_in = '0;
		out_ch.ready = 1'b0;
		words_issued = 0;
		words_accepted = 0;
		failure_count = 0;
		pad_trail = '0;
		gpio_data = '0;
		gpio_dir = '0;
		gpio_icr_lo = '0;
		gpio_icr_hi = '0;
		gpio_mask = '0;
		gpio_status = '0;
		gpio_edgesel = '0;
		gpio_pads = '0;
		send_idle_pct = 11;
		recv_idle_pct = 75;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values of every register
		for (int i = 0; i < 8; i++) begin
			push_word(OP_READ, reg_idx_t'(i), 32'h0, 32'h0);
		end
		// ICR fields cycle low/high/rise/fall per pin; top byte uses any-edge instead
		push_word(OP_WRITE, REG_ICR1, 32'he4e4_e4e4, 32'h0);
		push_word(OP_WRITE, REG_ICR2, 32'he4e4_e4e4, 32'h0);
		push_word(OP_WRITE, REG_MASK, 32'hffff_ffff, 32'h0);
		push_word(OP_WRITE, REG_EDGESEL, 32'hff00_0000, 32'h0);
		// first tick after reset judges edges against all-zero history
		push_word(OP_TICK, REG_DATA, 32'h0, 32'hffff_ffff);
		push_word(OP_READ, REG_STATUS, 32'h0, 32'h0);
		push_word(OP_WRITE, REG_STATUS, 32'hffff_ffff, 32'h0);
		push_word(OP_TICK, REG_DATA, 32'h0, 32'h0000_0000);
		push_word(OP_READ, REG_STATUS, 32'h0, 32'h0);
		push_word(OP_READ, REG_PSR, 32'h0, 32'hffff_ffff);
		// pad status write must not stick
		push_word(OP_WRITE, REG_PSR, 32'hdead_beef, 32'h0);
		push_word(OP_WRITE, REG_DATA, 32'hffff_ffff, 32'h0);
		push_word(OP_WRITE, REG_DIR, 32'hffff_ffff, 32'h0);
		// opcode three: a no-op that still returns a word
		push_word(OP_NONE, REG_STATUS, 32'hffff_ffff, 32'hffff_ffff);
		push_word(OP_TICK, REG_DATA, 32'h0, 32'h5555_aaaa);
		push_word(OP_WRITE, REG_MASK, 32'h0001_0000, 32'h0);
		push_word(OP_WRITE, REG_DATA, 32'h0, 32'h0);
		push_word(OP_WRITE, REG_DIR, 32'h0, 32'h0);
		pad_trail = 32'h5555_aaaa;

		// Phase one: slow receiver
		push_random(500);
		wait_drained();

		// Phase two: slow sender
		send_idle_pct = 75;
		recv_idle_pct = 11;
		push_random(500);
		wait_drained();

		// Phase three: full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random(500);
		wait_drained();

		// Trailing cycles catch any stray result word
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			log_failure("result word never arrived", expected_results[0], none);
		end
		if (failure_count == 0) begin
			$display("gpio_port_with_interrupts verification clean");
		end else begin
			$display("gpio_port_with_interrupts verification failed");
		end
		$finish;
	end

endmodule
